// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fsktd_pkg.sv =====
// Package with widths, constants and pipeline types of the 4FSK tone decision block.
`default_nettype none

package fsktd_pkg;

  localparam int TONE_COUNT = 4;
  localparam int MAG_W      = 31;
  localparam int TONE_W     = 2;
  localparam int MARGIN_W   = 10;
  localparam int QUO_W      = MARGIN_W;
  localparam int NUM_W      = MAG_W + QUO_W;
  localparam int PERMILLE   = 1000;
  localparam int IN_DATA_W  = ((TONE_COUNT * MAG_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TONE_W + MARGIN_W + 7) / 8) * 8;

  typedef logic [TONE_COUNT-1:0][MAG_W-1:0] mag_vec_t;

  typedef struct packed {
    logic [TONE_W-1:0] tone;
    logic              zero;
    logic [MAG_W-1:0]  divisor;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } div_item_t;

endpackage

`default_nettype wire

// ===== rtl/fsktd_select.sv =====
// Three-stage front end: pairwise compares, winner and runner-up pick, and scaling by 1000.
`default_nettype none

module fsktd_select
  import fsktd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mag_vec_t  mags,
  output logic           out_valid,
  input  wire logic      out_ready,
  output div_item_t      out_item
);

  logic             v1, v2, v3;
  logic             en1, en2, en3;
  logic             w01, w23;
  logic [MAG_W-1:0] max01, min01, max23, min23;
  logic [TONE_W-1:0] tone2;
  logic [MAG_W-1:0] best2, runner2;
  logic             pick23;
  logic [MAG_W-1:0] diff;
  div_item_t        item3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Within each pair the higher index wins only when strictly larger.
  always_ff @(posedge clk) begin
    if (en1) begin
      w01   <= mags[1] > mags[0];
      max01 <= (mags[1] > mags[0]) ? mags[1] : mags[0];
      min01 <= (mags[1] > mags[0]) ? mags[0] : mags[1];
      w23   <= mags[3] > mags[2];
      max23 <= (mags[3] > mags[2]) ? mags[3] : mags[2];
      min23 <= (mags[3] > mags[2]) ? mags[2] : mags[3];
    end
  end

  assign pick23 = max23 > max01;

  // The runner-up is the larger of the winning pair's loser and the other pair's maximum.
  always_ff @(posedge clk) begin
    if (en2) begin
      if (pick23) begin
        tone2   <= {1'b1, w23};
        best2   <= max23;
        runner2 <= (min23 > max01) ? min23 : max01;
      end else begin
        tone2   <= {1'b0, w01};
        best2   <= max01;
        runner2 <= (min01 > max23) ? min01 : max23;
      end
    end
  end

  assign diff = best2 - runner2;

  // Multiplication by 1000 written as 1024 - 16 - 8.
  always_ff @(posedge clk) begin
    if (en3) begin
      item3.tone    <= tone2;
      item3.zero    <= (best2 == '0);
      item3.divisor <= best2;
      item3.rem     <= {diff, QUO_W'(0)} - (NUM_W'(diff) << 4) - (NUM_W'(diff) << 3);
      item3.quo     <= '0;
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;

endmodule

`default_nettype wire

// ===== rtl/fsktd_div_step.sv =====
// One registered restoring-division step that yields one quotient bit.
`default_nettype none

module fsktd_div_step
  import fsktd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output div_item_t      out_item
);

  logic             v;
  logic             en;
  logic [NUM_W-1:0] shifted_div;
  logic             take;
  logic [NUM_W-1:0] rem_sub;
  div_item_t        item;

  assign en       = !v || out_ready;
  assign in_ready = en;

  // The partial remainder stays below the divisor times 2^QUO_W, so one fixed
  // compare against the divisor times 2^(QUO_W-1) decides each bit.
  assign shifted_div = {1'b0, in_item.divisor, (QUO_W - 1)'(0)};
  assign take        = in_item.rem >= shifted_div;
  assign rem_sub     = take ? (in_item.rem - shifted_div) : in_item.rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.tone    <= in_item.tone;
      item.zero    <= in_item.zero;
      item.divisor <= in_item.divisor;
      item.rem     <= {rem_sub[NUM_W-2:0], 1'b0};
      item.quo     <= {in_item.quo[QUO_W-2:0], take};
    end
  end

  assign out_valid = v;
  assign out_item  = item;

endmodule

`default_nettype wire

// ===== rtl/fsk_tone_decision_margin_top.sv =====
// Top level of the 4FSK hard decision with per-mille confidence margin.
//
// One beat on the input stream carries the four tone magnitudes of a symbol.
// One beat on the output stream carries the winning tone index (lowest index
// on a tie) and the margin of the winner over the runner-up in per mille of
// the winner, which is zero when all tones are zero.
// The pipeline has thirteen register stages: two for the tone compares, one
// for the subtraction and scaling by 1000, and ten restoring-division steps,
// one quotient bit each. Throughput is one beat per cycle while the receiver
// keeps tready high. Each stage moves forward whenever it is empty or the next
// stage moves, so bubbles are squeezed out and the input keeps accepting while
// the output waits, until every stage holds a beat.
// When the receiver holds tready low the output beat stays unchanged.
// A synchronous reset empties all stages; no beat is lost or repeated across
// a stall.
`default_nettype none

`include "assert_macros.svh"

module fsk_tone_decision_margin_top
  import fsktd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tone_mag_0, tone_mag_1, tone_mag_2, tone_mag_3, zero padding
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // winning_tone, margin_permille, zero padding
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  mag_vec_t  mags;
  logic      chain_valid [QUO_W+1];
  logic      chain_ready [QUO_W+1];
  div_item_t chain_item  [QUO_W+1];
  div_item_t last_item;
  logic [MARGIN_W-1:0] margin;

  assign mags = s_axis_tdata[TONE_COUNT*MAG_W-1:0];

  fsktd_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mags      (mags),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    fsktd_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  assign chain_ready[QUO_W] = m_axis_tready;
  assign last_item          = chain_item[QUO_W];
  assign margin             = last_item.zero ? '0 : last_item.quo;

  assign m_axis_tvalid = chain_valid[QUO_W];
  assign m_axis_tdata  = {(OUT_DATA_W - TONE_W - MARGIN_W)'(0), margin, last_item.tone};

  `ASSERT_ALWAYS(a_reset_empties, rst |=> !m_axis_tvalid, "output valid after reset")
  `ASSERT_CLK(a_margin_range, m_axis_tvalid |-> (margin <= MARGIN_W'(PERMILLE)), "margin above 1000")
  `ASSERT_CLK(a_full_only_when_stalled, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input blocked with room")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the 4FSK tone decision block with per-mille margin.
`timescale 1ns / 1ps

module tb
  import fsktd_pkg::*;
;

  typedef struct {
    logic [TONE_W-1:0]   tone;
    logic [MARGIN_W-1:0] margin;
  } decision_t;

  class decision_scoreboard;
    decision_t expected_decisions[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function void note_symbol(mag_vec_t mags);
      int unsigned      win;
      logic [MAG_W-1:0] runner;
      logic [63:0]      diff;
      decision_t        d;
      win = 0;
      for (int k = 1; k < TONE_COUNT; k++) begin
        if (mags[k] > mags[win]) win = k;
      end
      runner = '0;
      for (int k = 0; k < TONE_COUNT; k++) begin
        if (k != win && mags[k] > runner) runner = mags[k];
      end
      d.tone = win[TONE_W-1:0];
      d.margin = '0;
      if (mags[win] != '0) begin
        diff = 64'(mags[win]) - 64'(runner);
        d.margin = MARGIN_W'((diff * 64'(PERMILLE)) / 64'(mags[win]));
      end
      expected_decisions.push_back(d);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      decision_t d;
      if (expected_decisions.size() == 0) begin
        $error("Output beat with no symbol outstanding: tdata %h", data);
        errors++;
        return;
      end
      d = expected_decisions.pop_front();
      if (data[TONE_W-1:0] !== d.tone) begin
        $error("winning_tone: expected %0d, actual %0d", d.tone, data[TONE_W-1:0]);
        errors++;
      end
      if (data[TONE_W +: MARGIN_W] !== d.margin) begin
        $error("margin_permille: expected %0d, actual %0d", d.margin,
               data[TONE_W +: MARGIN_W]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_decisions.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  decision_scoreboard sb = new();

  fsk_tone_decision_margin_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic mag_vec_t symbol_of(logic [MAG_W-1:0] a, logic [MAG_W-1:0] b,
                                         logic [MAG_W-1:0] c, logic [MAG_W-1:0] d);
    mag_vec_t m;
    m[0] = a;
    m[1] = b;
    m[2] = c;
    m[3] = d;
    return m;
  endfunction

  function automatic logic [MAG_W-1:0] rand_mag();
    return MAG_W'($urandom);
  endfunction

  function automatic mag_vec_t random_symbol();
    mag_vec_t         m;
    int unsigned      hi;
    int unsigned      lo;
    logic [MAG_W-1:0] base;
    for (int k = 0; k < TONE_COUNT; k++) m[k] = rand_mag();
    case ($urandom_range(5))
      0: ;
      1: for (int k = 0; k < TONE_COUNT; k++) m[k] = MAG_W'($urandom_range(3));
      2: begin
        hi = $urandom_range(TONE_COUNT - 1);
        base = rand_mag() | (MAG_W'(1) << (MAG_W - 1));
        for (int k = 0; k < TONE_COUNT; k++) m[k] = (k == hi) ? base : (m[k] >> 2);
      end
      3: begin
        hi = $urandom_range(TONE_COUNT - 1);
        lo = $urandom_range(TONE_COUNT - 1);
        base = rand_mag() | MAG_W'(1024);
        for (int k = 0; k < TONE_COUNT; k++) begin
          if (m[k] >= base) m[k] = base >> 1;
        end
        m[hi] = base;
        if (lo != hi) m[lo] = base - MAG_W'($urandom_range(1000));
      end
      4: for (int k = 0; k < TONE_COUNT; k++) begin
        case ($urandom_range(2))
          0: m[k] = '0;
          1: m[k] = MAG_W'(1) << $urandom_range(MAG_W - 1);
          default: m[k] = m[k] >> $urandom_range(MAG_W - 1);
        endcase
      end
      default: begin
        hi = $urandom_range(TONE_COUNT - 1);
        lo = $urandom_range(TONE_COUNT - 1);
        m[lo] = m[hi];
      end
    endcase
    return m;
  endfunction

  task automatic send_symbol(input mag_vec_t mags);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= IN_DATA_W'(random_symbol());
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'(mags);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_symbol(mags);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  initial begin
    mag_vec_t directed[$];
    int unsigned idle_pcts[4] = '{0, 61, 0, 20};
    int unsigned stall_pcts[4] = '{0, 0, 61, 20};

    directed.push_back(symbol_of(0, 0, 0, 0));
    directed.push_back(symbol_of(MAG_MAX, MAG_MAX, MAG_MAX, MAG_MAX));
    directed.push_back(symbol_of(MAG_MAX, 0, 0, 0));
    directed.push_back(symbol_of(0, MAG_MAX, 0, 0));
    directed.push_back(symbol_of(0, 0, MAG_MAX, 0));
    directed.push_back(symbol_of(0, 0, 0, MAG_MAX));
    directed.push_back(symbol_of(MAG_MAX - 1, MAG_MAX, 0, 1));
    directed.push_back(symbol_of(1, 0, MAG_MAX - 1, MAG_MAX));
    directed.push_back(symbol_of(0, 0, 1, 0));
    directed.push_back(symbol_of(0, 7, 3, 7));
    directed.push_back(symbol_of(5, 2, 9, 9));
    directed.push_back(symbol_of(999, 1000, 0, 12));
    directed.push_back(symbol_of(1, 3, 0, 0));
    directed.push_back(symbol_of(1, 2, 3, 4));
    directed.push_back(symbol_of(4, 3, 2, 1));
    directed.push_back(symbol_of(31'h55555555, 31'h2AAAAAAA, 31'h2AAAAAAA, 31'h55555555));
    directed.push_back(symbol_of(31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA, 31'h55555554));
    directed.push_back(symbol_of(MAG_MAX, MAG_MAX - 1, MAG_MAX, 0));
    directed.push_back(symbol_of(0, 0, 0, 1));
    directed.push_back(symbol_of(31'h40000000, 31'h3FFFFFFF, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_symbol(directed[i]);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      for (int n = 0; n < 200; n++) send_symbol(random_symbol());
      drain_results();
    end

    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
